@@ hdl/tile_4bpp_transparent_blitter_core_assert.svh @@
// Assertion macros used by the checker of the tile blitter.
// Each macro expands to one labeled concurrent assertion on clock, disabled in reset.
`ifndef TILE_4BPP_TRANSPARENT_BLITTER_CORE_ASSERT_SVH
`define TILE_4BPP_TRANSPARENT_BLITTER_CORE_ASSERT_SVH

// The condition must hold at every clock edge outside reset.
`define TBB_ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error(msg);

// When the trigger holds, the consequence must hold at the next clock edge.
`define TBB_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/tbb_pkg.sv @@
// Shared types and constants of the 4bpp tile blitter.
// Used by every module of the block; depends on nothing.
package tbb_pkg;

   // Tile set and color parameters.
   localparam logic [12:0] TILE_COUNT    = 13'd1024;
   localparam int          PALETTE_SHIFT = 4;

   // Tile store as 32-bit words of four packed bytes (one half-row each).
   localparam int STORE_AW    = 15;
   localparam int STORE_WORDS = 1 << STORE_AW;

   // Index of the final half-row of a draw.
   localparam logic [4:0] LAST_HALF_ROW = 5'd31;

   // Left and top edge below which a draw is rejected.
   localparam logic signed [12:0] REJECT_LOW = -13'sd15;

   // Register reset values.
   localparam logic [10:0] DEST_WIDTH_RESET  = 11'd256;
   localparam logic [10:0] DEST_HEIGHT_RESET = 11'd224;

   // Item modes.
   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_DRAW = 1'b1;

   // Register indexes.
   localparam logic REG_DEST_WIDTH  = 1'b0;
   localparam logic REG_DEST_HEIGHT = 1'b1;

   // Destination size as seen by the clipping logic.
   typedef struct packed {
      logic [10:0] width;
      logic [10:0] height;
   } dims_type;

   // One classified request as it travels through the queue.
   typedef struct packed {
      logic               mode;
      logic [16:0]        store_addr;
      logic [7:0]         store_byte;
      logic [11:0]        tile;
      logic signed [11:0] pos_x;
      logic signed [11:0] pos_y;
      logic [7:0]         bank_add;
      logic               hflip;
      logic               vflip;
      logic               reject;
      logic               fill;
   } cmd_type;

   // Queue fill status.
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // Back end sequencer states.
   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_DRAW,
      BACK_WAIT
   } back_state_type;

endpackage

@@ hdl/tile_4bpp_transparent_blitter_core.sv @@
// The back end writes a load request to the tile store as it takes it; a draw sends its
// results through the read stage and the result register, one result per cycle for 32
// half-rows while rsp_stall is low, as set by the single read port of the tile store.
// A two-entry queue lets the front accept while a draw is running.
// Synchronous active-high reset clears control state and sets the destination to 256x224;
// the tile store is not cleared and holds undefined data until written.
module tile_4bpp_transparent_blitter_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [2:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_mode,
   input  logic [16:0]        req_store_addr,
   input  logic [7:0]         req_store_byte,
   input  logic [11:0]        req_tile_index,
   input  logic signed [11:0] req_pos_x,
   input  logic signed [11:0] req_pos_y,
   input  logic [3:0]         req_palette_bank,
   input  logic [1:0]         req_flip,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [11:0] rsp_out_x,
   output logic signed [11:0] rsp_out_y,
   output logic [63:0]        rsp_colors,
   output logic [7:0]         rsp_write_mask,
   output logic               rsp_last
);
   import tbb_pkg::*;

   logic [10:0]      dest_width_ff;
   logic [10:0]      dest_width_in;
   logic [10:0]      dest_height_ff;
   logic [10:0]      dest_height_in;
   logic             csr_write;
   dims_type         dims;
   queue_status_type queue_status;
   logic             push;
   cmd_type          push_cmd;
   logic             pop;
   cmd_type          head_cmd;

   // Register port: always ready, writes on the access cycle.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      dest_width_in  = dest_width_ff;
      dest_height_in = dest_height_ff;
      if (csr_write) begin
         case (csr_paddr[2])
            REG_DEST_WIDTH:  dest_width_in  = csr_pwdata[10:0];
            REG_DEST_HEIGHT: dest_height_in = csr_pwdata[10:0];
            default:         dest_width_in  = dest_width_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dest_width_ff  <= DEST_WIDTH_RESET;
         dest_height_ff <= DEST_HEIGHT_RESET;
      end else begin
         dest_width_ff  <= dest_width_in;
         dest_height_ff <= dest_height_in;
      end
   end

   // Register read-back.
   always_comb begin
      case (csr_paddr[2])
         REG_DEST_WIDTH:  csr_prdata = {21'b0, dest_width_ff};
         REG_DEST_HEIGHT: csr_prdata = {21'b0, dest_height_ff};
         default:         csr_prdata = '0;
      endcase
   end

   assign dims.width  = dest_width_ff;
   assign dims.height = dest_height_ff;

   tbb_front u_front (
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_store_addr   (req_store_addr),
      .req_store_byte   (req_store_byte),
      .req_tile_index   (req_tile_index),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_palette_bank (req_palette_bank),
      .req_flip         (req_flip),
      .dims             (dims),
      .queue_status     (queue_status),
      .push             (push),
      .push_cmd         (push_cmd)
   );

   tbb_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .pop_cmd  (head_cmd),
      .status   (queue_status)
   );

   tbb_back u_back (
      .clock          (clock),
      .reset          (reset),
      .dims           (dims),
      .queue_status   (queue_status),
      .head_cmd       (head_cmd),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_x      (rsp_out_x),
      .rsp_out_y      (rsp_out_y),
      .rsp_colors     (rsp_colors),
      .rsp_write_mask (rsp_write_mask),
      .rsp_last       (rsp_last)
   );

endmodule

@@ hdl/tbb_front.sv @@
// Front end of the tile blitter: accepts requests and classifies draws.
// Depends on tbb_pkg; feeds tbb_queue.
module tbb_front (
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_mode,
   input  logic [16:0]        req_store_addr,
   input  logic [7:0]         req_store_byte,
   input  logic [11:0]        req_tile_index,
   input  logic signed [11:0] req_pos_x,
   input  logic signed [11:0] req_pos_y,
   input  logic [3:0]         req_palette_bank,
   input  logic [1:0]         req_flip,
   input  tbb_pkg::dims_type  dims,
   input  tbb_pkg::queue_status_type queue_status,
   output logic               push,
   output tbb_pkg::cmd_type   push_cmd
);
   import tbb_pkg::*;

   logic signed [12:0] px;
   logic signed [12:0] py;
   logic signed [12:0] w;
   logic signed [12:0] h;

   // Accept whenever the queue has room.
   assign req_stall = queue_status.full;
   assign push      = req_valid && !queue_status.full;

   assign px = {req_pos_x[11], req_pos_x};
   assign py = {req_pos_y[11], req_pos_y};
   assign w  = $signed({2'b00, dims.width});
   assign h  = $signed({2'b00, dims.height});

   // Classify the draw: whole-tile reject, out-of-range fill, and color offset.
   always_comb begin
      push_cmd.mode       = req_mode;
      push_cmd.store_addr = req_store_addr;
      push_cmd.store_byte = req_store_byte;
      push_cmd.tile       = req_tile_index;
      push_cmd.pos_x      = req_pos_x;
      push_cmd.pos_y      = req_pos_y;
      push_cmd.bank_add   = 8'({4'b0000, req_palette_bank} << PALETTE_SHIFT);
      push_cmd.hflip      = req_flip[0];
      push_cmd.vflip      = req_flip[1];
      push_cmd.reject     = (px < REJECT_LOW) || (py < REJECT_LOW) || (py > h) ||
                            ((py == h) && (px > w));
      push_cmd.fill       = {1'b0, req_tile_index} >= TILE_COUNT;
   end

endmodule

@@ hdl/tbb_queue.sv @@
// Two-entry queue of classified requests between front and back end.
// Depends on tbb_pkg.
module tbb_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  tbb_pkg::cmd_type          push_cmd,
   input  logic                      pop,
   output tbb_pkg::cmd_type          pop_cmd,
   output tbb_pkg::queue_status_type status
);
   import tbb_pkg::*;

   cmd_type    entries_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;

   assign status.full  = count_ff == 2'd2;
   assign status.empty = count_ff == 2'd0;
   assign pop_cmd      = entries_ff[rd_ptr_ff];

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

@@ hdl/tbb_back.sv @@
// Back end of the tile blitter: tile store, draw sequencer and result register.
// Depends on tbb_pkg; takes requests from tbb_queue.
module tbb_back (
   input  logic                      clock,
   input  logic                      reset,
   input  tbb_pkg::dims_type         dims,
   input  tbb_pkg::queue_status_type queue_status,
   input  tbb_pkg::cmd_type          head_cmd,
   output logic                      pop,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [11:0]        rsp_out_x,
   output logic signed [11:0]        rsp_out_y,
   output logic [63:0]               rsp_colors,
   output logic [7:0]                rsp_write_mask,
   output logic                      rsp_last
);
   import tbb_pkg::*;

   // Tile store: one word holds the eight pixels of a half-row.
   logic [3:0][7:0] store_mem [STORE_WORDS];

   back_state_type     state_ff;
   back_state_type     state_in;
   cmd_type            cmd_ff;
   logic [4:0]         k_ff;
   logic [4:0]         k_in;
   logic               b_valid_ff;
   logic               b_valid_in;
   logic [4:0]         b_k_ff;
   logic [31:0]        rd_data_ff;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic signed [11:0] out_x_ff;
   logic signed [11:0] out_y_ff;
   logic [63:0]        colors_ff;
   logic [7:0]         mask_ff;
   logic               last_ff;

   logic                head_valid;
   logic                out_free;
   logic                b_take;
   logic                issue;
   logic                start;
   logic                mem_we;
   logic [3:0]          srow;
   logic                src_half;
   logic [STORE_AW-1:0] rd_addr;
   logic signed [12:0]  x0;
   logic signed [12:0]  dy;
   logic signed [12:0]  w;
   logic signed [12:0]  h;
   logic [63:0]         colors_in;
   logic [7:0]          mask_in;

   assign head_valid = !queue_status.empty;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign b_take     = !b_valid_ff || out_free;
   assign issue      = (state_ff == BACK_DRAW) && b_take;

   // Next state of the draw sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BACK_IDLE: begin
            if (head_valid && head_cmd.mode == MODE_DRAW) begin
               state_in = BACK_DRAW;
            end
         end
         BACK_DRAW: begin
            if (issue && k_ff == LAST_HALF_ROW) begin
               state_in = BACK_WAIT;
            end
         end
         BACK_WAIT: begin
            if (!b_valid_ff) begin
               state_in = BACK_IDLE;
            end
         end
         default: state_in = BACK_IDLE;
      endcase
   end

   // Sequencer outputs: take one request from the queue while idle.
   always_comb begin
      pop    = 1'b0;
      mem_we = 1'b0;
      start  = 1'b0;
      case (state_ff)
         BACK_IDLE: begin
            pop    = head_valid;
            mem_we = head_valid && head_cmd.mode == MODE_LOAD;
            start  = head_valid && head_cmd.mode == MODE_DRAW;
         end
         default: begin
            pop = 1'b0;
         end
      endcase
   end

   // Half-row counter.
   always_comb begin
      k_in = k_ff;
      if (start) begin
         k_in = 5'd0;
      end else if (issue) begin
         k_in = k_ff + 5'd1;
      end
   end

   // Source word of the half-row: mirrored rows and swapped halves under flip.
   assign srow     = cmd_ff.vflip ? ~k_ff[4:1] : k_ff[4:1];
   assign src_half = k_ff[0] ^ cmd_ff.hflip;
   assign rd_addr  = {cmd_ff.tile[9:0], srow, src_half};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         b_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         b_valid_ff   <= b_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Draw parameters and counters.
   always_ff @(posedge clock) begin
      k_ff <= k_in;
      if (start) begin
         cmd_ff <= head_cmd;
      end
      if (issue) begin
         b_k_ff <= k_ff;
      end
   end

   // Tile store: byte writes from loads, registered word reads for draws.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[head_cmd.store_addr[16:2]][head_cmd.store_addr[1:0]] <=
            head_cmd.store_byte;
      end
      if (issue) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   // Read stage holds its word until the result register takes it.
   always_comb begin
      b_valid_in = b_valid_ff;
      if (issue) begin
         b_valid_in = 1'b1;
      end else if (out_free) begin
         b_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (out_free) begin
         rsp_valid_in = b_valid_ff;
      end
   end

   // Pixel colors and clipping for the half-row in the read stage.
   assign w  = $signed({2'b00, dims.width});
   assign h  = $signed({2'b00, dims.height});
   assign x0 = $signed({cmd_ff.pos_x[11], cmd_ff.pos_x}) +
               $signed({9'b0, b_k_ff[0], 3'b000});
   assign dy = $signed({cmd_ff.pos_y[11], cmd_ff.pos_y}) + $signed({9'b0, b_k_ff[4:1]});

   always_comb begin
      logic [2:0]         pix;
      logic [3:0]         nib;
      logic signed [12:0] dx;
      logic               in_dest;
      logic               opaque;
      colors_in = '0;
      mask_in   = '0;
      for (int i = 0; i < 8; i++) begin
         // Under horizontal mirroring the word is read right to left.
         pix     = cmd_ff.hflip ? 3'(7 - i) : 3'(i);
         nib     = rd_data_ff[4*pix +: 4];
         dx      = x0 + $signed({10'b0, 3'(i)});
         in_dest = (dx >= 0) && (dx < w) && (dy >= 0) && (dy < h);
         opaque  = cmd_ff.fill || (nib != 4'd0);
         colors_in[8*i +: 8] = cmd_ff.fill ? 8'd0 : ({4'b0000, nib} + cmd_ff.bank_add);
         mask_in[i] = !cmd_ff.reject && in_dest && opaque;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (out_free && b_valid_ff) begin
         out_x_ff  <= x0[11:0];
         out_y_ff  <= dy[11:0];
         colors_ff <= colors_in;
         mask_ff   <= mask_in;
         last_ff   <= b_k_ff == LAST_HALF_ROW;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_x      = out_x_ff;
   assign rsp_out_y      = out_y_ff;
   assign rsp_colors     = colors_ff;
   assign rsp_write_mask = mask_ff;
   assign rsp_last       = last_ff;

endmodule

@@ hdl/tbb_checker.sv @@
// Port-level checker for the tile blitter, bound to the top level.
// Depends on the assertion macros in tile_4bpp_transparent_blitter_core_assert.svh.
`include "tile_4bpp_transparent_blitter_core_assert.svh"

module tbb_checker (
   input logic               clock,
   input logic               reset,
   input logic               csr_pready,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [11:0] rsp_out_x,
   input logic signed [11:0] rsp_out_y,
   input logic [63:0]        rsp_colors,
   input logic [7:0]         rsp_write_mask,
   input logic               rsp_last
);

   // A stalled result stays offered and unchanged.
   `TBB_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_out_x) && $stable(rsp_out_y) && $stable(rsp_colors) && $stable(rsp_write_mask) && $stable(rsp_last), "result changed while stalled")

   // The first cycle out of reset shows no result.
   `TBB_ASSERT_ALWAYS(a_reset_quiet, !$past(reset) || !rsp_valid, "result right after reset")

   // The register port never inserts wait states.
   `TBB_ASSERT_ALWAYS(a_pready, csr_pready, "register port not ready")

endmodule

bind tile_4bpp_transparent_blitter_core tbb_checker u_checker (.*);

@@ tb/blit_result_checker.sv @@
// Checker for the 4bpp tile blitter: mirrors the tile store and destination size, checks
// register reads, predicts the half-row results of every accepted draw and compares them.
// Depends on tbb_pkg for the mode, register and size constants.
module blit_result_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [2:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   input  logic [31:0]        csr_prdata,
   input  logic               csr_pready,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic               req_mode,
   input  logic [16:0]        req_store_addr,
   input  logic [7:0]         req_store_byte,
   input  logic [11:0]        req_tile_index,
   input  logic signed [11:0] req_pos_x,
   input  logic signed [11:0] req_pos_y,
   input  logic [3:0]         req_palette_bank,
   input  logic [1:0]         req_flip,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic signed [11:0] rsp_out_x,
   input  logic signed [11:0] rsp_out_y,
   input  logic [63:0]        rsp_colors,
   input  logic [7:0]         rsp_write_mask,
   input  logic               rsp_last,
   output int                 rows_pending,
   output int                 fail_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import tbb_pkg::*;

   // One predicted half-row of a draw.
   typedef struct {
      logic signed [11:0] x;
      logic signed [11:0] y;
      logic [63:0]        colors;
      logic [7:0]         mask;
      logic               last;
   } half_row_type;

   logic [7:0]   store_mirror [0:131071];
   logic [10:0]  width_q;
   logic [10:0]  height_q;
   half_row_type expected_half_rows [$];
   int           mismatches = 0;

   // Expands one draw request into its 32 half-rows, top row first, left half first.
   function automatic void predict_half_rows(input logic [11:0] tile,
                                             input logic signed [11:0] pos_x,
                                             input logic signed [11:0] pos_y,
                                             input logic [3:0] bank,
                                             input logic [1:0] flip);
      int        px, py, w, h, dy, x0, dx, r, srow, c, scol;
      logic      reject, fill, in_dest, opaque;
      logic [7:0] bank_add, color;
      logic [3:0] nib;
      logic [16:0] addr;
      half_row_type row;
      px = pos_x;
      py = pos_y;
      w = width_q;
      h = height_q;
      reject = px < -15 || py < -15 || py > h || (py == h && px > w);
      fill = (tile >= TILE_COUNT);
      bank_add = {4'b0000, bank} << PALETTE_SHIFT;
      for (int k = 0; k < 32; k++) begin
         r = k / 2;
         dy = py + r;
         x0 = px + (k % 2) * 8;
         srow = flip[1] ? 15 - r : r;
         row.colors = '0;
         row.mask = '0;
         for (int i = 0; i < 8; i++) begin
            c = (k % 2) * 8 + i;
            scol = flip[0] ? 15 - c : c;
            dx = x0 + i;
            in_dest = dx >= 0 && dx < w && dy >= 0 && dy < h;
            // An out-of-range tile paints opaque color zero.
            if (fill) begin
               color = 8'h00;
               opaque = 1'b1;
            end else begin
               addr = 17'(tile * 128 + srow * 8 + scol / 2);
               nib = scol[0] ? store_mirror[addr][7:4] : store_mirror[addr][3:0];
               color = nib + bank_add;
               opaque = (nib != 4'h0);
            end
            row.colors[8*i +: 8] = color;
            if (!reject && in_dest && opaque) begin
               row.mask[i] = 1'b1;
            end
         end
         row.x = x0[11:0];
         row.y = dy[11:0];
         row.last = (k == LAST_HALF_ROW);
         expected_half_rows.push_back(row);
      end
   endfunction

   function automatic void compare_field(input string field, input logic [63:0] want,
                                         input logic [63:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, want, got);
         mismatches++;
      end
   endfunction

   // Register port, result channel and request channel, all sampled at the clock edge.
   always @(posedge clock) begin : watch
      half_row_type want;
      logic [31:0]  reg_value;
      if (reset) begin
         width_q = DEST_WIDTH_RESET;
         height_q = DEST_HEIGHT_RESET;
         expected_half_rows.delete();
      end else begin
         // Register writes take effect here; reads must return the held size.
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) begin
               if (csr_paddr[2] == REG_DEST_WIDTH) begin
                  width_q = csr_pwdata[10:0];
               end else begin
                  height_q = csr_pwdata[10:0];
               end
            end else begin
               reg_value = {21'b0, (csr_paddr[2] == REG_DEST_WIDTH) ? width_q : height_q};
               compare_field("csr_prdata", reg_value, csr_prdata);
            end
         end

         // Each delivered half-row is matched against the oldest prediction.
         if (rsp_valid && !rsp_stall) begin
            if (expected_half_rows.size() == 0) begin
               $error("unexpected half-row at x=%0d y=%0d", rsp_out_x, rsp_out_y);
               mismatches++;
            end else begin
               want = expected_half_rows.pop_front();
               compare_field("out_x", $unsigned(want.x), $unsigned(rsp_out_x));
               compare_field("out_y", $unsigned(want.y), $unsigned(rsp_out_y));
               compare_field("colors", want.colors, rsp_colors);
               compare_field("write_mask", want.mask, rsp_write_mask);
               compare_field("last", want.last, rsp_last);
            end
         end

         // Loads update the store copy; draws queue their half-rows.
         if (req_valid && !req_stall) begin
            if (req_mode == MODE_LOAD) begin
               store_mirror[req_store_addr] = req_store_byte;
            end else begin
               predict_half_rows(req_tile_index, req_pos_x, req_pos_y, req_palette_bank,
                                 req_flip);
            end
         end
      end
      rows_pending <= expected_half_rows.size();
      fail_count <= mismatches;
   end

endmodule

@@ tb/tile_4bpp_transparent_blitter_core_tb.sv @@
// Top of the 4bpp tile blitter testbench: clock, reset, register writes and reads,
// load and draw requests with random gaps and result stalls. Needs tbb_pkg, the core
// and blit_result_checker, which does all prediction and comparison.
module tile_4bpp_transparent_blitter_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import tbb_pkg::*;

   localparam int RESET_CYCLES = 12;
   localparam int DRAIN_CYCLES = 16;
   localparam int MAX_TILES    = 2;
   localparam int RUN_LIMIT_NS = 2_000_000;
   localparam int PHASES       = 7;

   typedef enum int {STALL_NONE, STALL_COIN, STALL_BURST} stall_mode_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_psel = 1'b0;
   logic               csr_penable = 1'b0;
   logic               csr_pwrite = 1'b0;
   logic [2:0]         csr_paddr = '0;
   logic [31:0]        csr_pwdata = '0;
   logic [31:0]        csr_prdata;
   logic               csr_pready;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_mode = MODE_LOAD;
   logic [16:0]        req_store_addr = '0;
   logic [7:0]         req_store_byte = '0;
   logic [11:0]        req_tile_index = '0;
   logic signed [11:0] req_pos_x = '0;
   logic signed [11:0] req_pos_y = '0;
   logic [3:0]         req_palette_bank = '0;
   logic [1:0]         req_flip = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [11:0] rsp_out_x;
   logic signed [11:0] rsp_out_y;
   logic [63:0]        rsp_colors;
   logic [7:0]         rsp_write_mask;
   logic               rsp_last;
   int                 rows_pending;
   int                 fail_count;

   // Which store bytes have been written, and which tiles are complete and safe to draw.
   bit         byte_seen [0:131071];
   int         tile_bytes_seen [0:1023];
   logic [9:0] ready_tiles [$];
   int         tiles_loaded = 0;
   int         burst_left = 0;
   int         cur_w = 256;
   int         cur_h = 224;

   tile_4bpp_transparent_blitter_core u_dut (.*);
   blit_result_checker u_checker (.*);

   always #1 clock = ~clock;

   // Result side stalls on its own pattern: none, coin flips, or on/off runs.
   stall_mode_type stall_mode = STALL_NONE;
   int             mode_left = 0;
   int             stall_left = 0;
   logic           stall_on = 1'b0;
   always @(posedge clock) begin
      if (mode_left == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 2));
         mode_left = $urandom_range(50, 300);
      end else begin
         mode_left--;
      end
      case (stall_mode)
         STALL_NONE: begin
            rsp_stall <= 1'b0;
         end
         STALL_COIN: begin
            rsp_stall <= 1'($urandom_range(0, 1));
         end
         default: begin
            if (stall_left == 0) begin
               stall_left = $urandom_range(1, 6);
               stall_on = ~stall_on;
            end
            stall_left--;
            rsp_stall <= stall_on;
         end
      endcase
   end

   // Sends one request, opening a new burst after a random gap when the last one ran out.
   task automatic issue_request(input logic mode, input logic [16:0] addr,
                                input logic [7:0] data, input logic [11:0] tile,
                                input logic signed [11:0] px, input logic signed [11:0] py,
                                input logic [3:0] bank, input logic [1:0] flip);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_mode <= mode;
      req_store_addr <= addr;
      req_store_byte <= data;
      req_tile_index <= tile;
      req_pos_x <= px;
      req_pos_y <= py;
      req_palette_bank <= bank;
      req_flip <= flip;
      do @(posedge clock); while (req_stall);
      // A tile becomes drawable once all of its 128 bytes have been written.
      if (mode == MODE_LOAD && !byte_seen[addr]) begin
         byte_seen[addr] = 1'b1;
         tile_bytes_seen[addr[16:7]]++;
         if (tile_bytes_seen[addr[16:7]] == 128) begin
            ready_tiles.push_back(addr[16:7]);
         end
      end
   endtask

   task automatic load_byte(input logic [16:0] addr, input logic [7:0] data);
      issue_request(MODE_LOAD, addr, data, 12'($urandom), 12'($urandom), 12'($urandom),
                    4'($urandom), 2'($urandom));
   endtask

   task automatic draw_tile(input logic [11:0] tile, input int px, input int py,
                            input logic [3:0] bank, input logic [1:0] flip);
      issue_request(MODE_DRAW, 17'($urandom), 8'($urandom), tile, 12'(px), 12'(py),
                    bank, flip);
   endtask

   // Fills a whole tile; the first bytes hold the nibble extremes.
   task automatic load_tile(input logic [9:0] tile);
      logic [7:0] data;
      for (int b = 0; b < 128; b++) begin
         case (b)
            0: data = 8'h0F;
            1: data = 8'hF0;
            2: data = 8'h00;
            3: data = 8'hFF;
            default: data = 8'($urandom);
         endcase
         load_byte({tile, 7'(b)}, data);
      end
      tiles_loaded++;
   endtask

   // Holds the sender until every half-row has come and the back end has settled.
   task automatic wait_drained();
      req_valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (rows_pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // One register access, after which the port is returned to idle.
   task automatic csr_access(input logic write, input logic idx, input logic [10:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= write;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= {21'b0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // Mostly near the destination so clipping and the reject edges are hit.
   function automatic int pick_coord(input int span);
      int v;
      if ($urandom_range(0, 9) < 7) begin
         v = $urandom_range(0, span + 24);
         v = v - 20;
         if (v > 2047) begin
            v = 2047;
         end
      end else begin
         v = $signed(12'($urandom));
      end
      return v;
   endfunction

   task automatic run_random(input int count);
      int pick;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 6 && tiles_loaded < MAX_TILES) begin
            load_tile(10'($urandom));
         end else if (pick < 16) begin
            load_byte(17'($urandom), 8'($urandom));
         end else if (pick < 28) begin
            draw_tile(12'($urandom_range(int'(TILE_COUNT), 4095)), pick_coord(cur_w),
                      pick_coord(cur_h), 4'($urandom), 2'($urandom));
         end else begin
            draw_tile({2'b00, ready_tiles[$urandom_range(0, ready_tiles.size() - 1)]},
                      pick_coord(cur_w), pick_coord(cur_h), 4'($urandom), 2'($urandom));
         end
         if ($urandom_range(0, 49) == 0) begin
            wait_drained();
         end
      end
   endtask

   // Run limit.
   initial begin
      #(RUN_LIMIT_NS);
      $display("Regression FAIL");
      $finish;
   end

   // Stimulus and verdict.
   initial begin
      int phase_w [PHASES];
      int phase_h [PHASES];
      int phase_items [PHASES];
      phase_w = '{1, 1024, 0, 256, 2047, 0, 256};
      phase_h = '{1, 1024, 224, 0, 2047, 0, 224};
      phase_items = '{6, 6, 6, 6, 6, 8, 7};
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed part at the reset size of 256x224.
      load_tile(10'd0);
      load_tile(10'd1023);
      draw_tile(12'd0, 0, 0, 4'd0, 2'd0);
      draw_tile(12'd0, 16, 0, 4'd15, 2'd1);
      draw_tile(12'd0, 32, 16, 4'd5, 2'd2);
      draw_tile(12'd0, 48, 16, 4'd10, 2'd3);
      draw_tile(12'd1023, 100, 50, 4'd15, 2'd3);
      // Just inside the left and top reject bounds, then just past them.
      draw_tile(12'd1023, -15, -15, 4'd0, 2'd0);
      draw_tile(12'd0, -16, 20, 4'd1, 2'd0);
      draw_tile(12'd0, 20, -16, 4'd2, 2'd1);
      // Below the bottom edge, and on it just past and exactly at the right edge.
      draw_tile(12'd0, 20, 225, 4'd3, 2'd0);
      draw_tile(12'd0, 257, 224, 4'd4, 2'd0);
      draw_tile(12'd0, 256, 224, 4'd4, 2'd0);
      draw_tile(12'd0, 248, 216, 4'd6, 2'd2);
      // Out-of-range tiles give an opaque zero fill that is still clipped.
      draw_tile(12'd1024, -8, -8, 4'd3, 2'd0);
      draw_tile(12'd4095, 250, 220, 4'd15, 2'd3);
      // Coordinate extremes, where the output position wraps.
      draw_tile(12'd0, 2047, 100, 4'd7, 2'd1);
      draw_tile(12'd0, -2048, -2048, 4'd8, 2'd2);
      draw_tile(12'd1023, 10, 2047, 4'd9, 2'd0);
      // A load between draws must be seen by the next draw.
      load_byte(17'h00000, 8'h00);
      load_byte(17'h1FFFF, 8'hA5);
      draw_tile(12'd0, 0, 0, 4'd15, 2'd0);
      draw_tile(12'd1023, 200, 200, 4'd0, 2'd3);

      // Random phases, each under its own destination size.
      for (int p = 0; p < PHASES; p++) begin
         wait_drained();
         cur_w = phase_w[p];
         cur_h = phase_h[p];
         if (p == 5) begin
            cur_w = $urandom_range(1, 1024);
            cur_h = $urandom_range(1, 1024);
         end
         csr_access(1'b1, REG_DEST_WIDTH, 11'(cur_w));
         csr_access(1'b1, REG_DEST_HEIGHT, 11'(cur_h));
         csr_access(1'b0, REG_DEST_WIDTH, 11'd0);
         csr_access(1'b0, REG_DEST_HEIGHT, 11'd0);
         run_random(phase_items[p]);
      end

      wait_drained();
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/tbb_pkg.sv
hdl/tbb_front.sv
hdl/tbb_queue.sv
hdl/tbb_back.sv
hdl/tile_4bpp_transparent_blitter_core.sv
hdl/tbb_checker.sv
tb/blit_result_checker.sv
tb/tile_4bpp_transparent_blitter_core_tb.sv
